// ----- rtl/core/bqb_pkg.sv -----
// Shared types and constants for the bracket and quote balance checker.
package bqb_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int OFFSET_BITS = 24;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CP_W        = 21;
    localparam int FLAG_OFF_W  = 24;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_AW     = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

    localparam logic [CP_W-1:0] CH_LPAREN  = CP_W'(8'h28);
    localparam logic [CP_W-1:0] CH_RPAREN  = CP_W'(8'h29);
    localparam logic [CP_W-1:0] CH_LSQUARE = CP_W'(8'h5B);
    localparam logic [CP_W-1:0] CH_RSQUARE = CP_W'(8'h5D);
    localparam logic [CP_W-1:0] CH_LCURLY  = CP_W'(8'h7B);
    localparam logic [CP_W-1:0] CH_RCURLY  = CP_W'(8'h7D);
    localparam logic [CP_W-1:0] CH_BSLASH  = CP_W'(8'h5C);
    localparam logic [CP_W-1:0] CH_SQUOTE  = CP_W'(8'h27);
    localparam logic [CP_W-1:0] CH_DQUOTE  = CP_W'(8'h22);

    typedef enum logic [2:0] {
        CL_OTHER,
        CL_BSLASH,
        CL_SQUOTE,
        CL_DQUOTE,
        CL_OPEN,
        CL_CLOSE
    } char_cls_t;

    typedef enum logic [1:0] {
        BK_ROUND,
        BK_SQUARE,
        BK_CURLY,
        BK_NONE
    } bkind_t;

    typedef enum logic [2:0] {
        FK_UNMATCHED,
        FK_UNCLOSED,
        FK_OPEN_QUOTE,
        FK_END,
        FK_OVERFLOW
    } flag_kind_t;

    typedef enum logic [2:0] {
        BS_RUN,
        BS_CLOSE,
        BS_END,
        BS_DRAIN,
        BS_QUOTE,
        BS_FINAL
    } back_state_t;

    typedef struct packed {
        char_cls_t cls;
        bkind_t    bkind;
        logic      last;
    } cmd_t;

    typedef struct packed {
        flag_kind_t            kind;
        logic [FLAG_OFF_W-1:0] off;
        logic                  last;
    } res_t;

    typedef struct packed {
        bkind_t                 bkind;
        logic [OFFSET_BITS-1:0] off;
    } stk_entry_t;

endpackage

// ----- rtl/core/bqb_front.sv -----
// Front end: accepts code points, classifies them and hands them to the command queue.
module bqb_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [bqb_pkg::CP_W-1:0] code_point,
    input  logic                     text_end,
    input  logic                     q_full,
    output logic                     q_push,
    output bqb_pkg::cmd_t            q_data
);

    logic          valid_reg;
    logic          valid_next;
    bqb_pkg::cmd_t item_reg;
    bqb_pkg::cmd_t item_next;
    logic          accept;
    logic          move;

    assign move   = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = move;
    assign q_data = item_reg;

    always_comb
    begin
        item_next.last = text_end;
        unique case (code_point)
            bqb_pkg::CH_LPAREN:
            begin
                item_next.cls   = bqb_pkg::CL_OPEN;
                item_next.bkind = bqb_pkg::BK_ROUND;
            end
            bqb_pkg::CH_LSQUARE:
            begin
                item_next.cls   = bqb_pkg::CL_OPEN;
                item_next.bkind = bqb_pkg::BK_SQUARE;
            end
            bqb_pkg::CH_LCURLY:
            begin
                item_next.cls   = bqb_pkg::CL_OPEN;
                item_next.bkind = bqb_pkg::BK_CURLY;
            end
            bqb_pkg::CH_RPAREN:
            begin
                item_next.cls   = bqb_pkg::CL_CLOSE;
                item_next.bkind = bqb_pkg::BK_ROUND;
            end
            bqb_pkg::CH_RSQUARE:
            begin
                item_next.cls   = bqb_pkg::CL_CLOSE;
                item_next.bkind = bqb_pkg::BK_SQUARE;
            end
            bqb_pkg::CH_RCURLY:
            begin
                item_next.cls   = bqb_pkg::CL_CLOSE;
                item_next.bkind = bqb_pkg::BK_CURLY;
            end
            bqb_pkg::CH_BSLASH:
            begin
                item_next.cls   = bqb_pkg::CL_BSLASH;
                item_next.bkind = bqb_pkg::BK_NONE;
            end
            bqb_pkg::CH_SQUOTE:
            begin
                item_next.cls   = bqb_pkg::CL_SQUOTE;
                item_next.bkind = bqb_pkg::BK_NONE;
            end
            bqb_pkg::CH_DQUOTE:
            begin
                item_next.cls   = bqb_pkg::CL_DQUOTE;
                item_next.bkind = bqb_pkg::BK_NONE;
            end
            default:
            begin
                item_next.cls   = bqb_pkg::CL_OTHER;
                item_next.bkind = bqb_pkg::BK_NONE;
            end
        endcase
    end

    assign valid_next = accept || (valid_reg && !move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/core/bqb_cmdq.sv -----
// Short command queue between the front end and the back end.
module bqb_cmdq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bqb_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output bqb_pkg::cmd_t head
);

    bqb_pkg::cmd_t                  mem [bqb_pkg::CMDQ_DEPTH];
    logic [bqb_pkg::CMDQ_AW-1:0]    wr_ptr_reg;
    logic [bqb_pkg::CMDQ_AW-1:0]    wr_ptr_next;
    logic [bqb_pkg::CMDQ_AW-1:0]    rd_ptr_reg;
    logic [bqb_pkg::CMDQ_AW-1:0]    rd_ptr_next;
    logic [bqb_pkg::CMDQ_CW-1:0]    cnt_reg;
    logic [bqb_pkg::CMDQ_CW-1:0]    cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (cnt_reg == bqb_pkg::CMDQ_CW'(bqb_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/bqb_back.sv -----
// Back end: quote and escape tracking, bracket stack and flag generation.
module bqb_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  bqb_pkg::cmd_t cmd_head,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output bqb_pkg::res_t res_data
);

    localparam logic [bqb_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [bqb_pkg::CNT_W-1:0] CNT_FULL =
        bqb_pkg::CNT_W'(bqb_pkg::STACK_DEPTH);

    bqb_pkg::back_state_t               state_reg;
    bqb_pkg::back_state_t               state_next;
    logic [bqb_pkg::OFFSET_BITS-1:0]    offset_reg;
    logic [bqb_pkg::OFFSET_BITS-1:0]    offset_next;
    logic [bqb_pkg::OFFSET_BITS-1:0]    pos_reg;
    logic [bqb_pkg::OFFSET_BITS-1:0]    pos_next;
    logic                               in_single_reg;
    logic                               in_single_next;
    logic                               in_double_reg;
    logic                               in_double_next;
    logic                               esc_reg;
    logic                               esc_next;
    logic [bqb_pkg::CNT_W-1:0]          count_reg;
    logic [bqb_pkg::CNT_W-1:0]          count_next;
    bqb_pkg::bkind_t                    ckind_reg;
    bqb_pkg::bkind_t                    ckind_next;
    logic                               last_reg;
    logic                               last_next;

    bqb_pkg::stk_entry_t                stack_mem [bqb_pkg::STACK_DEPTH];
    bqb_pkg::stk_entry_t                rd_data_reg;
    bqb_pkg::stk_entry_t                wr_data;
    logic                               mem_we;
    logic [bqb_pkg::ADDR_W-1:0]         wr_addr;
    logic [bqb_pkg::ADDR_W-1:0]         rd_addr;

    logic                               quoted;
    logic                               take;
    logic                               close_rd;
    logic [bqb_pkg::OFFSET_BITS-1:0]    off_inc;

    assign quoted  = in_single_reg || in_double_reg;
    assign take    = (state_reg == bqb_pkg::BS_RUN) && !cmd_empty && !res_full;
    // unquoted closing on a nonempty stack needs the top entry from memory
    assign close_rd = !esc_reg && (cmd_head.cls == bqb_pkg::CL_CLOSE) && !quoted
                      && (count_reg != '0);
    assign off_inc = (offset_reg == OFF_MAX) ? offset_reg : offset_reg + 1'b1;
    assign wr_addr = bqb_pkg::ADDR_W'(count_reg);
    assign rd_addr = bqb_pkg::ADDR_W'(count_reg - 1'b1);
    assign wr_data = '{bkind: cmd_head.bkind, off: offset_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bqb_pkg::BS_RUN:
            begin
                if (take)
                begin
                    if (close_rd)
                    begin
                        state_next = bqb_pkg::BS_CLOSE;
                    end
                    else if (cmd_head.last)
                    begin
                        state_next = bqb_pkg::BS_END;
                    end
                end
            end
            bqb_pkg::BS_CLOSE:
            begin
                if (!res_full)
                begin
                    state_next = last_reg ? bqb_pkg::BS_END : bqb_pkg::BS_RUN;
                end
            end
            bqb_pkg::BS_END:
            begin
                if (count_reg != '0)
                begin
                    state_next = bqb_pkg::BS_DRAIN;
                end
                else if (quoted)
                begin
                    state_next = bqb_pkg::BS_QUOTE;
                end
                else
                begin
                    state_next = bqb_pkg::BS_FINAL;
                end
            end
            bqb_pkg::BS_DRAIN:
            begin
                if (!res_full)
                begin
                    state_next = bqb_pkg::BS_END;
                end
            end
            bqb_pkg::BS_QUOTE:
            begin
                if (!res_full)
                begin
                    state_next = bqb_pkg::BS_FINAL;
                end
            end
            bqb_pkg::BS_FINAL:
            begin
                if (!res_full)
                begin
                    state_next = bqb_pkg::BS_RUN;
                end
            end
            default:
            begin
                state_next = bqb_pkg::BS_RUN;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_data       = '{kind: bqb_pkg::FK_END, off: '0, last: 1'b0};
        mem_we         = 1'b0;
        offset_next    = offset_reg;
        pos_next       = pos_reg;
        in_single_next = in_single_reg;
        in_double_next = in_double_reg;
        esc_next       = esc_reg;
        count_next     = count_reg;
        ckind_next     = ckind_reg;
        last_next      = last_reg;
        unique case (state_reg)
            bqb_pkg::BS_RUN:
            begin
                if (take)
                begin
                    cmd_pop     = 1'b1;
                    offset_next = off_inc;
                    pos_next    = offset_reg;
                    ckind_next  = cmd_head.bkind;
                    last_next   = cmd_head.last;
                    priority if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (cmd_head.cls == bqb_pkg::CL_BSLASH && quoted)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (cmd_head.cls == bqb_pkg::CL_SQUOTE && !in_double_reg)
                    begin
                        in_single_next = !in_single_reg;
                    end
                    else if (cmd_head.cls == bqb_pkg::CL_DQUOTE && !in_single_reg)
                    begin
                        in_double_next = !in_double_reg;
                    end
                    else if (cmd_head.cls == bqb_pkg::CL_OPEN && !quoted)
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            res_push = 1'b1;
                            res_data = '{kind: bqb_pkg::FK_OVERFLOW,
                                         off: bqb_pkg::FLAG_OFF_W'(offset_reg),
                                         last: !cmd_head.last};
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd_head.cls == bqb_pkg::CL_CLOSE && !quoted
                             && count_reg == '0)
                    begin
                        res_push = 1'b1;
                        res_data = '{kind: bqb_pkg::FK_UNMATCHED,
                                     off: bqb_pkg::FLAG_OFF_W'(offset_reg),
                                     last: !cmd_head.last};
                    end
                    else
                    begin
                        esc_next = esc_reg;
                    end
                end
            end
            bqb_pkg::BS_CLOSE:
            begin
                if (!res_full)
                begin
                    if (rd_data_reg.bkind == ckind_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        res_push = 1'b1;
                        res_data = '{kind: bqb_pkg::FK_UNMATCHED,
                                     off: bqb_pkg::FLAG_OFF_W'(pos_reg),
                                     last: !last_reg};
                    end
                end
            end
            bqb_pkg::BS_END:
            begin
                // lets the stack read settle on the new top
            end
            bqb_pkg::BS_DRAIN:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_data   = '{kind: bqb_pkg::FK_UNCLOSED,
                                   off: bqb_pkg::FLAG_OFF_W'(rd_data_reg.off),
                                   last: 1'b0};
                    count_next = count_reg - 1'b1;
                end
            end
            bqb_pkg::BS_QUOTE:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    res_data = '{kind: bqb_pkg::FK_OPEN_QUOTE,
                                 off: bqb_pkg::FLAG_OFF_W'(pos_reg),
                                 last: 1'b0};
                end
            end
            bqb_pkg::BS_FINAL:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res_data       = '{kind: bqb_pkg::FK_END,
                                       off: bqb_pkg::FLAG_OFF_W'(offset_reg),
                                       last: 1'b1};
                    offset_next    = '0;
                    in_single_next = 1'b0;
                    in_double_next = 1'b0;
                    esc_next       = 1'b0;
                    count_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bqb_pkg::BS_RUN;
            offset_reg    <= '0;
            in_single_reg <= 1'b0;
            in_double_reg <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            in_single_reg <= in_single_next;
            in_double_reg <= in_double_next;
            esc_reg       <= esc_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        ckind_reg <= ckind_next;
        last_reg  <= last_next;
    end

    // stack memory, registered read of the current top
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

endmodule

// ----- rtl/core/bqb_resq.sv -----
// Result queue feeding the output side.
module bqb_resq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bqb_pkg::res_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output bqb_pkg::res_t head
);

    bqb_pkg::res_t                  mem [bqb_pkg::RESQ_DEPTH];
    logic [bqb_pkg::RESQ_AW-1:0]    wr_ptr_reg;
    logic [bqb_pkg::RESQ_AW-1:0]    wr_ptr_next;
    logic [bqb_pkg::RESQ_AW-1:0]    rd_ptr_reg;
    logic [bqb_pkg::RESQ_AW-1:0]    rd_ptr_next;
    logic [bqb_pkg::RESQ_CW-1:0]    cnt_reg;
    logic [bqb_pkg::RESQ_CW-1:0]    cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (cnt_reg == bqb_pkg::RESQ_CW'(bqb_pkg::RESQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/bracket_quote_balance_checker.sv -----
// Flag path: a code point is registered in the front end, passes the command queue and is flagged
//   by the back end into the result queue; a closing bracket on a nonempty stack waits for BS_CLOSE.
// Throughput: 1 code point per cycle while the back end is in BS_RUN and the result queue has room;
//   an unquoted closing bracket on a nonempty stack adds BS_CLOSE (registered read of the stack top).
// End of text: BS_END and BS_DRAIN per unclosed bracket, BS_QUOTE for an open quote, BS_FINAL for the end result.
// Reset: rst_n clears offset, quote, escape and stack count at once; the stack memory
//   itself is not cleared.
module bracket_quote_balance_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bqb_pkg::CP_W-1:0]       code_point,
    input  logic                           text_end,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     flag_kind,
    output logic [bqb_pkg::FLAG_OFF_W-1:0] flag_offset,
    output logic                           run_last
);

    logic          cq_push;
    logic          cq_full;
    logic          cq_pop;
    logic          cq_empty;
    bqb_pkg::cmd_t cq_in;
    bqb_pkg::cmd_t cq_head;
    logic          rq_push;
    logic          rq_full;
    bqb_pkg::res_t rq_in;
    bqb_pkg::res_t rq_head;

    bqb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_point (code_point),
        .text_end   (text_end),
        .q_full     (cq_full),
        .q_push     (cq_push),
        .q_data     (cq_in)
    );

    bqb_cmdq u_cmdq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cq_push),
        .push_data  (cq_in),
        .full       (cq_full),
        .pop        (cq_pop),
        .empty      (cq_empty),
        .head       (cq_head)
    );

    bqb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cq_empty),
        .cmd_head   (cq_head),
        .cmd_pop    (cq_pop),
        .res_full   (rq_full),
        .res_push   (rq_push),
        .res_data   (rq_in)
    );

    bqb_resq u_resq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rq_push),
        .push_data  (rq_in),
        .full       (rq_full),
        .pop        (pop),
        .empty      (empty),
        .head       (rq_head)
    );

    assign flag_kind   = rq_head.kind;
    assign flag_offset = rq_head.off;
    assign run_last    = rq_head.last;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the bracket and quote balance checker.
module testbench;
    import bqb_pkg::*;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
        bit              hold;   // wait for all pending flags before sending
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CP_W-1:0]       code_point = '0;
    logic                  text_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            flag_kind;
    logic [FLAG_OFF_W-1:0] flag_offset;
    logic                  run_last;

    bracket_quote_balance_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .code_point  (code_point),
        .text_end    (text_end),
        .empty       (empty),
        .pop         (pop),
        .flag_kind   (flag_kind),
        .flag_offset (flag_offset),
        .run_last    (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    // Scanner state mirrored from the text stream.
    logic [OFFSET_BITS-1:0] char_off = '0;
    logic                   in_sq = 1'b0;
    logic                   in_dq = 1'b0;
    logic                   esc = 1'b0;
    stk_entry_t             open_brackets [STACK_DEPTH];
    int                     open_depth = 0;

    text_char_t text_q [$];
    res_t       flag_q [$];
    text_char_t sent;
    res_t       want;
    int         mismatches = 0;
    int         drv_gap = 0;
    int         drv_calm = 0;
    int         mon_gap = 0;
    int         mon_calm = 0;

    function automatic bkind_t bracket_of(logic [CP_W-1:0] cp, bit closing);
        if (cp == (closing ? CH_RPAREN : CH_LPAREN))
            return BK_ROUND;
        if (cp == (closing ? CH_RSQUARE : CH_LSQUARE))
            return BK_SQUARE;
        if (cp == (closing ? CH_RCURLY : CH_LCURLY))
            return BK_CURLY;
        return BK_NONE;
    endfunction

    function automatic logic [CP_W-1:0] bracket_char(bkind_t k, bit closing);
        case (k)
            BK_ROUND:  return closing ? CH_RPAREN : CH_LPAREN;
            BK_SQUARE: return closing ? CH_RSQUARE : CH_LSQUARE;
            default:   return closing ? CH_RCURLY : CH_LCURLY;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] random_cp();
        int r;
        logic [CP_W-1:0] cp;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return CP_W'($urandom_range(32, 126));
        if (r == 6)
            return CP_W'($urandom);
        case ($urandom_range(0, 8))
            0: cp = CH_LPAREN;
            1: cp = CH_RPAREN;
            2: cp = CH_LSQUARE;
            3: cp = CH_RSQUARE;
            4: cp = CH_LCURLY;
            5: cp = CH_RCURLY;
            6: cp = CH_BSLASH;
            7: cp = CH_SQUOTE;
            default: cp = CH_DQUOTE;
        endcase
        // same low byte as a special character, but a different code point
        if (r == 7)
            cp[CP_W-1:8] = (CP_W-8)'($urandom_range(1, 8191));
        return cp;
    endfunction

    task automatic expect_flag(flag_kind_t k, logic [OFFSET_BITS-1:0] off);
        flag_q.push_back('{k, FLAG_OFF_W'(off), 1'b0});
    endtask

    task automatic scan_code_point(logic [CP_W-1:0] cp, logic last);
        logic [OFFSET_BITS-1:0] pos;
        logic                   quoted;
        bkind_t                 opening;
        bkind_t                 closing;
        int                     base;
        res_t                   tail;
        pos = char_off;
        quoted = in_sq || in_dq;
        opening = bracket_of(cp, 1'b0);
        closing = bracket_of(cp, 1'b1);
        base = flag_q.size();

        if (esc)
            esc = 1'b0;
        else if (cp == CH_BSLASH && quoted)
            esc = 1'b1;
        else if (cp == CH_SQUOTE && !in_dq)
            in_sq = !in_sq;
        else if (cp == CH_DQUOTE && !in_sq)
            in_dq = !in_dq;
        else if (!quoted && opening != BK_NONE)
        begin
            if (open_depth >= STACK_DEPTH)
                expect_flag(FK_OVERFLOW, pos);
            else
            begin
                open_brackets[open_depth] = '{opening, pos};
                open_depth++;
            end
        end
        else if (!quoted && closing != BK_NONE)
        begin
            if (open_depth > 0 && open_brackets[open_depth-1].bkind == closing)
                open_depth--;
            else
                expect_flag(FK_UNMATCHED, pos);
        end

        if (char_off != {OFFSET_BITS{1'b1}})
            char_off = char_off + 1'b1;

        if (last)
        begin
            while (open_depth > 0)
            begin
                open_depth--;
                expect_flag(FK_UNCLOSED, open_brackets[open_depth].off);
            end
            if (in_sq || in_dq)
                expect_flag(FK_OPEN_QUOTE, pos);
            expect_flag(FK_END, char_off);
            char_off = '0;
            in_sq = 1'b0;
            in_dq = 1'b0;
            esc = 1'b0;
        end

        if (flag_q.size() > base)
        begin
            tail = flag_q.pop_back();
            tail.last = 1'b1;
            flag_q.push_back(tail);
        end
    endtask

    task automatic next_gap(inout int gap, inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
            if ($urandom_range(0, 24) == 0)
                calm = $urandom_range(20, 60);
        end
    endtask

    task automatic push_char(logic [CP_W-1:0] cp, logic last, bit hold);
        text_q.push_back('{cp, last, hold});
    endtask

    // deep: number of leading openings; noise: content without structure
    task automatic add_text(int len, int deep, bit noise, bit hold);
        bkind_t          nest [$];
        bkind_t          k;
        logic [CP_W-1:0] cp;
        int              r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            k = bkind_t'($urandom_range(0, 2));
            if (i < deep)
                cp = bracket_char(k, 1'b0);
            else if (noise || r >= 61)
                cp = random_cp();
            else if (r < 24)
            begin
                cp = bracket_char(k, 1'b0);
                nest.push_back(k);
            end
            else if (r < 44 && nest.size() > 0)
                cp = bracket_char(nest.pop_back(), 1'b1);
            else if (r < 48)
                cp = bracket_char(k, 1'b1);
            else if (r < 56)
                cp = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            else
                cp = CH_BSLASH;
            push_char(cp, i == len - 1, hold && i == 0);
        end
    endtask

    // Sender: one transaction per accepted code point.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sent = text_q.pop_front();
                scan_code_point(sent.cp, sent.last);
                next_gap(drv_gap, drv_calm);
            end
            if (!push || !full)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    push <= 1'b0;
                end
                else if (text_q.size() > 0 && !(text_q[0].hold && flag_q.size() > 0))
                begin
                    push <= 1'b1;
                    code_point <= text_q[0].cp;
                    text_end <= text_q[0].last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: checks each flag transaction against the oldest expected flag.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (flag_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected flag: kind %0d offset %0d last %0b",
                                 flag_kind, flag_offset, run_last);
                end
                else
                begin
                    want = flag_q.pop_front();
                    if (flag_kind != want.kind || flag_offset != want.off
                        || run_last != want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("flag mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                                     want.kind, want.off, want.last,
                                     flag_kind, flag_offset, run_last);
                    end
                end
                next_gap(mon_gap, mon_calm);
            end
            else if (pop && $urandom_range(0, 15) == 0)
                mon_gap = $urandom_range(1, 4);

            if (mon_gap > 0)
            begin
                mon_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        // Code points above Unicode, a lookalike of '(' and code point zero.
        push_char(CP_W'(21'h1FFFFF), 1'b0, 1'b0);
        push_char(CP_W'(21'h000128), 1'b0, 1'b0);
        push_char(CP_W'(21'h000000), 1'b1, 1'b0);
        // mismatched closing with the stack unchanged
        push_char(CH_LPAREN, 1'b0, 1'b0);
        push_char(CH_LSQUARE, 1'b0, 1'b0);
        push_char(CH_RCURLY, 1'b0, 1'b0);
        push_char(CH_RSQUARE, 1'b0, 1'b0);
        push_char(CH_RPAREN, 1'b1, 1'b0);
        // closing on an empty stack
        push_char(CH_RPAREN, 1'b1, 1'b0);
        // escaped quote, double quote and bracket inside single quotes
        push_char(CH_LCURLY, 1'b0, 1'b0);
        push_char(CH_SQUOTE, 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char(CH_SQUOTE, 1'b0, 1'b0);
        push_char(CH_DQUOTE, 1'b0, 1'b0);
        push_char(CH_LPAREN, 1'b0, 1'b0);
        push_char(CH_SQUOTE, 1'b1, 1'b0);
        // open quote at end, escape still pending
        push_char(CH_DQUOTE, 1'b0, 1'b0);
        push_char(CH_BSLASH, 1'b1, 1'b0);
        // backslash outside quotes escapes nothing
        push_char(CH_BSLASH, 1'b0, 1'b0);
        push_char(CH_LPAREN, 1'b1, 1'b0);
        // bracket inside double quotes is ignored
        push_char(CH_LSQUARE, 1'b0, 1'b0);
        push_char(CH_DQUOTE, 1'b0, 1'b0);
        push_char(CH_RSQUARE, 1'b0, 1'b0);
        push_char(CH_DQUOTE, 1'b0, 1'b0);
        push_char(CH_RSQUARE, 1'b1, 1'b0);

        // Full stack plus overflow, then an open quote: most flags from one transaction.
        // Sent only once the directed flags have all come back.
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            push_char(bracket_char(bkind_t'($urandom_range(0, 2)), 1'b0), 1'b0, i == 0);
        push_char(CH_DQUOTE, 1'b1, 1'b0);

        while (text_q.size() < 280)
        begin
            int r;
            bit hold;
            r = $urandom_range(0, 99);
            hold = ($urandom_range(0, 9) == 0);
            if (r < 8)
                add_text($urandom_range(34, 44), $urandom_range(30, 36), 1'b0, hold);
            else if (r < 20)
                add_text($urandom_range(1, 10), 0, 1'b1, hold);
            else if (r < 30)
                add_text($urandom_range(13, 28), 0, 1'b0, hold);
            else
                add_text($urandom_range(1, 12), 0, 1'b0, hold);
        end

        @(posedge rst_n);
        do
            @(posedge clk);
        while (text_q.size() > 0 || flag_q.size() > 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- bracket_quote_balance_checker.f -----
rtl/core/bqb_pkg.sv
rtl/core/bqb_front.sv
rtl/core/bqb_cmdq.sv
rtl/core/bqb_back.sv
rtl/core/bqb_resq.sv
rtl/core/bracket_quote_balance_checker.sv
tb/testbench.sv
